/* design/ahp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahp_pkg: shared types and helpers for the adts header parser
// status codes, the queue entry carried from front to back, header constants
// ----------------------------------------------------------------------------
package ahp_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SYNC_ERR  = 2'd1,
        ST_TRUNC     = 2'd2,
        ST_SHORT_LEN = 2'd3
    } ahp_status_t;

    localparam int AHP_QUEUE_DEPTH = 2;
    localparam int HDR_W           = 48;     // header bytes 2..7, byte 2 on top
    localparam int FLEN_W          = 13;
    localparam int PHASE_W         = 3;

    localparam logic [PHASE_W-1:0] PH_FIRST = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SECOND = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LAST_HDR = 3'd6;
    localparam logic [PHASE_W-1:0] PH_SKIP = 3'd7;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [3:0] SYNC_NIBBLE = 4'hF;
    localparam logic [FLEN_W-1:0] HDR_BYTES = 13'd7;

    typedef struct packed {
        ahp_status_t        status;
        logic [HDR_W-1:0]   hdr;
    } ahp_entry_t;

    // frame length from header bytes 4..6
    function automatic logic [FLEN_W-1:0] ahp_frame_len(input logic [HDR_W-1:0] hdr);
        ahp_frame_len = {hdr[25:24], hdr[23:16], hdr[15:13]};
    endfunction

endpackage

/* design/ahp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahp_front: byte acceptance and frame tracking
// checks sync, gathers header bytes, skips frame bodies, queues results
// ----------------------------------------------------------------------------
module ahp_front
    import ahp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  logic [7:0]         data_byte,
    input  logic               end_of_stream,
    output logic               byte_ready,
    input  logic               q_full,
    output logic               push,
    output ahp_entry_t         push_entry
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [HDR_W-1:0]   hs_reg, hs_next;
    logic [FLEN_W-1:0]  skip_reg, skip_next;
    logic               halted_reg, halted_next;

    logic               take;
    logic [HDR_W-1:0]   hs_shift;
    logic [FLEN_W-1:0]  skip_dec;
    logic [FLEN_W-1:0]  flen;
    logic [FLEN_W-1:0]  body_len;
    logic               sync_fail;

    assign byte_ready = !q_full;
    assign take       = byte_valid && byte_ready;
    assign hs_shift   = (phase_reg >= PH_SECOND) ? {hs_reg[HDR_W-9:0], data_byte} : hs_reg;
    assign skip_dec   = skip_reg - FLEN_W'(1);
    assign flen       = ahp_frame_len(hs_shift);
    assign body_len   = flen - HDR_BYTES;
    assign sync_fail  = (phase_reg == PH_FIRST && data_byte != SYNC_BYTE)
                     || (phase_reg == PH_SECOND && data_byte[7:4] != SYNC_NIBBLE);

    always_comb
    begin
        phase_next  = phase_reg;
        hs_next     = hs_reg;
        skip_next   = skip_reg;
        halted_next = halted_reg;
        push        = 1'b0;
        push_entry  = '{status: ST_OK, hdr: '0};
        if (take && !halted_reg)
        begin
            if (phase_reg == PH_SKIP)
            begin
                if (skip_dec == '0 || end_of_stream)
                begin
                    skip_next  = '0;
                    phase_next = PH_FIRST;
                end
                else
                begin
                    skip_next = skip_dec;
                end
            end
            else if (sync_fail)
            begin
                halted_next       = 1'b1;
                phase_next        = PH_FIRST;
                push              = 1'b1;
                push_entry.status = ST_SYNC_ERR;
            end
            else if (phase_reg < PH_LAST_HDR)
            begin
                if (end_of_stream)
                begin
                    phase_next        = PH_FIRST;
                    hs_next           = '0;
                    push              = 1'b1;
                    push_entry.status = ST_TRUNC;
                end
                else
                begin
                    phase_next = phase_reg + PHASE_W'(1);
                    hs_next    = hs_shift;
                end
            end
            else
            begin
                // seventh byte completes the header
                hs_next        = '0;
                phase_next     = PH_FIRST;
                push           = 1'b1;
                push_entry.hdr = hs_shift;
                if (flen < HDR_BYTES)
                begin
                    push_entry.status = ST_SHORT_LEN;
                    halted_next       = 1'b1;
                end
                else if (body_len != '0 && !end_of_stream)
                begin
                    skip_next  = body_len;
                    phase_next = PH_SKIP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            hs_reg     <= '0;
            skip_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hs_reg     <= hs_next;
            skip_reg   <= skip_next;
            halted_reg <= halted_next;
        end
    end

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !push)
        else $error("result queued while halted");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (skip_reg != '0))
        else $error("skipping with zero count");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

endmodule

/* design/ahp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahp_queue: short result queue
// decouples the byte front from the output stage
// ----------------------------------------------------------------------------
module ahp_queue
    import ahp_pkg::*;
#(
    parameter int DEPTH = AHP_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ahp_entry_t push_entry,
    input  logic       pop,
    output ahp_entry_t pop_entry,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ahp_entry_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not advance");

endmodule

/* design/ahp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahp_back: header decode and output register
// splits a queued header into its fields and holds it for the sink
// ----------------------------------------------------------------------------
module ahp_back
    import ahp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  ahp_entry_t  q_entry,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] out_data,
    output logic [1:0]  out_status
);

    logic        valid_reg;
    logic [47:0] data_reg, data_next;
    logic [1:0]  status_reg;

    logic [7:0] b1, b2, b3, b5, b6;

    assign b1 = q_entry.hdr[47:40];
    assign b2 = q_entry.hdr[39:32];
    assign b3 = q_entry.hdr[31:24];
    assign b5 = q_entry.hdr[15:8];
    assign b6 = q_entry.hdr[7:0];

    assign pop = !q_empty && (!valid_reg || out_ready);

    always_comb
    begin
        data_next        = '0;
        data_next[1:0]   = b2[7:6];                                // profile
        data_next[5:2]   = b2[5:2];                                // freq index
        data_next[8:6]   = {b2[0], b3[7:6]};                       // channels
        data_next[10:9]  = b1[2:1];                                // layer
        data_next[17:11] = {b1[3], b1[0], b2[1], b3[5], b3[4], b3[3], b3[2]};
        data_next[30:18] = ahp_frame_len(q_entry.hdr);
        data_next[41:31] = {b5[4:0], b6[7:2]};                     // fullness
        data_next[43:42] = b6[1:0];                                // raw blocks
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg   <= data_next;
            status_reg <= q_entry.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid  = valid_reg;
    assign out_data   = data_reg;
    assign out_status = status_reg;

endmodule

/* design/adts_header_parser_top.sv */
`timescale 1ns / 1ps
// the byte transaction that completes a result writes it into the result queue; it then
// moves into the output register, which drives m_axis_tvalid, once that register is free
// throughput: one byte per cycle unless the result queue is full; the queue absorbs result bursts
// a stalled sink backs up through the result queue into s_axis_tready
// reset: rst_n asynchronous, active low; clears phase, skip count, halt, queue, output valid
// no clearing pass after reset: the parser takes bytes in the first cycle out of reset
// ----------------------------------------------------------------------------
// adts_header_parser_top: aac adts header parser
// streams raw adts bytes, reports each frame header, skips frame bodies
// ----------------------------------------------------------------------------
module adts_header_parser_top
    import ahp_pkg::*;
#(
    parameter int QUEUE_DEPTH = AHP_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_stream
    // header results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [1:0] profile, [5:2] freq_index,
                                        // [8:6] channel_config, [10:9] layer,
                                        // [17:11] flag_bits, [30:18] frame length,
                                        // [41:31] fullness, [43:42] raw_blocks,
                                        // [47:44] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    // front to queue
    logic       push;
    ahp_entry_t push_entry;
    logic       q_full;

    // queue to back
    logic       pop;
    logic       q_empty;
    ahp_entry_t q_entry;

    // front: sync check, header gather, body skip, halt on fatal errors
    ahp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (s_axis_tvalid),
        .data_byte     (s_axis_tdata),
        .end_of_stream (s_axis_tlast),
        .byte_ready    (s_axis_tready),
        .q_full        (q_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    // result queue: raw header bytes plus status, one entry per result transaction
    ahp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (q_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    // back: field decode into the output register
    ahp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_entry    (q_entry),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_status (m_axis_tuser)
    );

endmodule

/* verif/adts_header_parser_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adts_header_parser_top_tb: self-checking bench for the adts header parser
// feeds adts byte streams through the byte input, predicts every header result
// from its own parser state, and checks each result field by field
// ----------------------------------------------------------------------------
module adts_header_parser_top_tb
    import ahp_pkg::*;
();

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int TARGET_BYTES = 1900;
    localparam int IDLE_LIMIT   = 5000;   // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 20;     // results pass through the queue and the output register, leave margin

    // one predicted header result: status plus the packed result word
    typedef struct packed {
        ahp_status_t status;
        logic [47:0] fields;
    } hdr_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: tracks the parser state and holds the pending header results
    // ------------------------------------------------------------------------
    class header_scoreboard;
        logic [PHASE_W-1:0] phase;
        logic [HDR_W-1:0]   header_bytes;   // header bytes 2..7, byte 2 on top
        logic [FLEN_W-1:0]  skip_left;
        bit                 halted;
        hdr_result_t        expected_q[$];
        int                 mismatches;
        int                 checked;

        function new();
            phase        = PH_FIRST;
            header_bytes = '0;
            skip_left    = '0;
            halted       = 1'b0;
            mismatches   = 0;
            checked      = 0;
        endfunction

        // advance the parser by one accepted byte, queue the result it causes
        function void note_byte(logic [7:0] b, logic eos);
            hdr_result_t res;
            logic [7:0]  h1, h2, h3, h4, h5, h6;
            logic [FLEN_W-1:0] flen;
            res.status = ST_OK;
            res.fields = '0;
            if (halted)
                return;
            // frame body: count down, end of stream cuts it short
            if (phase == PH_SKIP)
            begin
                skip_left = skip_left - 13'd1;
                if (skip_left == '0 || eos)
                begin
                    skip_left = '0;
                    phase     = PH_FIRST;
                end
                return;
            end
            // sync word check wins over end of stream on the same byte
            if ((phase == PH_FIRST && b != SYNC_BYTE) ||
                (phase == PH_SECOND && b[7:4] != SYNC_NIBBLE))
            begin
                halted     = 1'b1;
                phase      = PH_FIRST;
                res.status = ST_SYNC_ERR;
                expected_q.push_back(res);
                return;
            end
            if (phase != PH_FIRST)
                header_bytes = {header_bytes[HDR_W-9:0], b};
            if (phase != PH_LAST_HDR)
            begin
                if (eos)
                begin
                    phase        = PH_FIRST;
                    header_bytes = '0;
                    res.status   = ST_TRUNC;
                    expected_q.push_back(res);
                    return;
                end
                phase = phase + 3'd1;
                return;
            end
            // seventh byte: decode the whole header
            {h1, h2, h3, h4, h5, h6} = header_bytes;
            flen = {h3[1:0], h4, h5[7:5]};
            res.fields = {4'd0, h6[1:0], h5[4:0], h6[7:2], flen,
                          h1[3], h1[0], h2[1], h3[5:2],
                          h1[2:1], h2[0], h3[7:6], h2[5:2], h2[7:6]};
            header_bytes = '0;
            phase        = PH_FIRST;
            if (flen < HDR_BYTES)
            begin
                res.status = ST_SHORT_LEN;
                halted     = 1'b1;
            end
            else
            begin
                skip_left = flen - HDR_BYTES;
                if (skip_left != '0 && !eos)
                    phase = PH_SKIP;
                else
                    skip_left = '0;
            end
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            $display("[%0t] result %0d: %s", $realtime, checked, msg);
            mismatches++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // compare one accepted result with the oldest pending one
        task check_result(logic [1:0] st, logic [47:0] data);
            hdr_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result, status %0d data %h", st, data));
                return;
            end
            want = expected_q.pop_front();
            compare_field("status",          st,           want.status);
            compare_field("profile",         data[1:0],    want.fields[1:0]);
            compare_field("freq_index",      data[5:2],    want.fields[5:2]);
            compare_field("channel_config",  data[8:6],    want.fields[8:6]);
            compare_field("layer",           data[10:9],   want.fields[10:9]);
            compare_field("flag_bits",       data[17:11],  want.fields[17:11]);
            compare_field("frame_len",       data[30:18],  want.fields[30:18]);
            compare_field("fullness",        data[41:31],  want.fields[41:31]);
            compare_field("raw_blocks",      data[43:42],  want.fields[43:42]);
            compare_field("pad bits",        data[47:44],  want.fields[47:44]);
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, dut
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    header_scoreboard sb = new();

    int burst_left = 0;     // bytes left in the current sender burst
    int sent_count = 0;     // bytes accepted so far
    int idle_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    adts_header_parser_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // monitors: results checked before the input of the same edge is noted,
    // a byte can never produce its result in the cycle it is accepted
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    // watchdog: ends the run if neither side moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result sink: picks a new stall pattern after each stretch of random length
    // ------------------------------------------------------------------------
    initial
    begin : sink
        int mode;
        int stretch;
        int tick;
        tick = 0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(50, 300);
            repeat (stretch)
            begin
                @(negedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;                            // never stalls
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);     // light stalls
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);     // heavy stalls
                    default: m_axis_tready <= ((tick % 9) < 3);          // periodic
                endcase
                tick++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // byte source
    // ------------------------------------------------------------------------

    // one byte transaction; bursts of random length with random gaps between
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
    endtask

    // random header with a valid sync word and the given frame length
    function automatic logic [55:0] make_header(input logic [FLEN_W-1:0] flen);
        logic [55:0] h;
        h = {SYNC_BYTE, SYNC_NIBBLE, 4'($urandom), 32'($urandom), 8'($urandom)};
        h[25:24] = flen[12:11];
        h[23:16] = flen[10:3];
        h[15:13] = flen[2:0];
        return h;
    endfunction

    // header bytes, then body bytes; trunc_at < 0 means a complete header;
    // only the truncating byte, the seventh byte or the last body byte may carry the end of stream flag
    task automatic send_frame(input logic [55:0] hdr, input int trunc_at,
                              input bit seventh_last, input int body_n,
                              input bit body_last);
        for (int i = 0; i < 7; i++)
        begin
            if (i == trunc_at)
            begin
                send_byte(hdr[55 - 8 * i -: 8], 1'b1);
                return;
            end
            send_byte(hdr[55 - 8 * i -: 8], (i == 6) && seventh_last);
        end
        for (int i = 0; i < body_n; i++)
            send_byte(8'($urandom), body_last && (i == body_n - 1));
    endtask

    // well-formed frame with random content, sometimes cut short
    task automatic send_random_frame();
        int          pick;
        int          flen;
        int          body_n;
        bit          seventh_last;
        bit          body_last;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            send_frame(make_header(13'($urandom_range(7, 40))), $urandom_range(0, 5),
                       1'b0, 0, 1'b0);
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
            flen = 7;
        else if (pick < 75)
            flen = $urandom_range(8, 24);
        else if (pick < 90)
            flen = $urandom_range(25, 200);
        else
            flen = $urandom_range(201, 8191);
        seventh_last = ($urandom_range(0, 9) == 0);
        body_n    = 0;
        body_last = 1'b0;
        if (!seventh_last && flen > 7)
        begin
            if (flen > 200)
            begin
                // long frame: end of stream inside the body keeps it cheap
                body_n    = $urandom_range(1, 20);
                body_last = 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                body_n    = $urandom_range(1, flen - 7);
                body_last = 1'b1;
            end
            else
            begin
                body_n    = flen - 7;
                body_last = 1'($urandom_range(0, 1));
            end
        end
        send_frame(make_header(13'(flen)), -1, seventh_last, body_n, body_last);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int          ending;
        logic [7:0]  bad;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes of the header fields and the stream edge cases
        // shortest legal frame, every other field zero
        send_frame({SYNC_BYTE, 8'hF0, 8'h00, 8'h00, 8'h00, 8'hE0, 8'h00}, -1, 1'b0, 0, 1'b0);
        // every header bit set, longest frame, body cut by end of stream
        send_frame({7{8'hFF}}, -1, 1'b0, 2, 1'b1);
        // one body byte carrying the end of stream flag
        send_frame(make_header(13'd8), -1, 1'b0, 1, 1'b1);
        // end of stream inside the header, at first, middle and sixth byte
        send_frame(make_header(13'd20), 0, 1'b0, 0, 1'b0);
        send_frame(make_header(13'd20), 3, 1'b0, 0, 1'b0);
        send_frame(make_header(13'd20), 5, 1'b0, 0, 1'b0);
        // end of stream on the seventh byte: next byte starts a new frame
        send_frame(make_header(13'd20), -1, 1'b1, 0, 1'b0);
        // end of stream inside the body
        send_frame(make_header(13'd30), -1, 1'b0, 2, 1'b1);
        // exact body skip
        send_frame(make_header(13'd10), -1, 1'b0, 3, 1'b0);

        // random well-formed frames
        while (sent_count < TARGET_BYTES)
            send_random_frame();

        // the parser halts until reset, so exactly one halting case closes the run
        ending = $urandom_range(0, 2);
        case (ending)
            0:
            begin
                // sync failure on the first byte, end of stream flag ignored
                bad = 8'($urandom_range(0, 254));
                send_byte(bad, 1'($urandom));
            end
            1:
            begin
                // sync failure on the second byte
                bad = {4'($urandom_range(0, 14)), 4'($urandom)};
                send_byte(SYNC_BYTE, 1'b0);
                send_byte(bad, 1'($urandom));
            end
            default:
                // complete header with a frame length below seven
                send_frame(make_header(13'($urandom_range(0, 6))), -1,
                           1'($urandom), 0, 1'b0);
        endcase
        // halted: these must all be swallowed without a result
        send_byte(SYNC_BYTE, 1'b0);
        repeat (7) send_byte(8'($urandom), 1'($urandom));

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // drain, then give a stray result time to show up
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
